/* rtl/tbdp_pkg.sv */
// ----------------------------------------------------------------------------
// tbdp_pkg
// Shared types, codes, defaults and helpers of the tournament branch
// direction predictor.
// ----------------------------------------------------------------------------
package tbdp_pkg;

  // Default table geometry
  localparam int unsigned BimodEntriesDef  = 1024;
  localparam int unsigned ChoiceEntriesDef = 1024;
  localparam int unsigned HistoryRegsDef   = 1;
  localparam int unsigned PhtColumnsDef    = 64;
  localparam int unsigned HistoryBitsDef   = 8;

  // Result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // Predictor modes (six and seven are unused codes)
  typedef enum logic [2:0] {
    MODE_PERFECT   = 3'd0,
    MODE_TAKEN     = 3'd1,
    MODE_NOT_TAKEN = 3'd2,
    MODE_BIMODAL   = 3'd3,
    MODE_TWO_LEVEL = 3'd4,
    MODE_COMBINED  = 3'd5
  } mode_e;

  localparam logic [2:0] ModeReset = 3'd5;

  // Item opcodes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // 2-bit counter values
  localparam logic [1:0] CtrMin        = 2'd0;
  localparam logic [1:0] CtrWeakTaken  = 2'd2;
  localparam logic [1:0] CtrMax        = 2'd3;

  // One result item
  typedef struct packed {
    logic       predict_taken;
    logic       bimod_prediction;
    logic       twolevel_prediction;
    logic       choice_prediction;
    logic [7:0] history_row;
  } result_t;

  // Saturating 2-bit counter step
  function automatic logic [1:0] train(input logic [1:0] ctr, input logic up);
    logic [1:0] res;
    if (up) begin
      res = (ctr == CtrMax) ? CtrMax : ctr + 2'd1;
    end else begin
      res = (ctr == CtrMin) ? CtrMin : ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

/* rtl/tbdp_ram.sv */
// ----------------------------------------------------------------------------
// tbdp_ram
// Generic single write port, single read port RAM with registered read
// (read returns the old contents on a same-address write).
// ----------------------------------------------------------------------------
module tbdp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tbdp_clear.sv */
// ----------------------------------------------------------------------------
// tbdp_clear
// Post-reset sweep counter; walks every table index once so the tables can
// be loaded with their reset values.
// ----------------------------------------------------------------------------
module tbdp_clear #(
  parameter int unsigned CLEAR_LEN = 16384,
  parameter int unsigned CW        = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          active_o,
  output logic [CW-1:0] idx_o
);

  logic          active_q, active_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Advance until the last index has been written
  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (active_q) begin
      if (32'(cnt_q) == 32'(CLEAR_LEN - 1)) begin
        active_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  assign active_o = active_q;
  assign idx_o    = cnt_q;

endmodule

/* rtl/tbdp_fifo.sv */
// ----------------------------------------------------------------------------
// tbdp_fifo
// Small result queue between the lookup pipeline and the output channel.
// Reports its fill level so the input side can reserve room.
// ----------------------------------------------------------------------------
module tbdp_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  tbdp_pkg::result_t                 push_data_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output tbdp_pkg::result_t                 data_o,
  output logic [tbdp_pkg::FifoCntW-1:0]     count_o
);

  tbdp_pkg::result_t                 buf_q [tbdp_pkg::FifoDepth];
  logic [tbdp_pkg::FifoPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [tbdp_pkg::FifoCntW-1:0]     cnt_q;
  logic                              pop;

  assign pop = valid_o && ready_i;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + tbdp_pkg::FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + tbdp_pkg::FifoPtrW'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + tbdp_pkg::FifoCntW'(1);
      end else if (!push_i && pop) begin
        cnt_q <= cnt_q - tbdp_pkg::FifoCntW'(1);
      end
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

/* rtl/tournament_branch_direction_predictor.sv */
// ----------------------------------------------------------------------------
// tournament_branch_direction_predictor
// Bimodal / two-level / combined branch direction predictor with lookup and
// update items on one valid/ready input channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries lookup or update items;
//   output channel (out_valid_o/out_ready_i) returns one result per item,
//   in order. Config channel (cfg_valid_i/cfg_ready_o) writes the mode
//   register; it is always ready. It must be written only while the block
//   is idle; the block does not enforce this. Result path: history read,
//   then counter tables read, then result queue.
//   Throughput: one item per cycle unless in_ready_o is low; the pipeline
//   is a history RAM stage followed by the counter RAM stage, each RAM with
//   one read and one write port; adjacent-item hazards resolved by forwarding.
//   Reset: mode returns to combined, then a sweep writes every table entry
//   to its reset value, one index per cycle; in_ready_o is low during
//   the sweep.
//   Receiver stall: results wait in a four-entry queue; in_ready_o drops
//   once queued plus in-flight items would fill it.
// ----------------------------------------------------------------------------
module tournament_branch_direction_predictor #(
  parameter int unsigned BIMOD_ENTRIES  = tbdp_pkg::BimodEntriesDef,
  parameter int unsigned CHOICE_ENTRIES = tbdp_pkg::ChoiceEntriesDef,
  parameter int unsigned HISTORY_REGS   = tbdp_pkg::HistoryRegsDef,
  parameter int unsigned PHT_COLUMNS    = tbdp_pkg::PhtColumnsDef,
  parameter int unsigned HISTORY_BITS   = tbdp_pkg::HistoryBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] pc_i,
  input  logic        is_uncond_i,
  input  logic        is_internal_i,
  input  logic        taken_i,
  input  logic        saved_bimod_pred_i,
  input  logic        saved_twolevel_pred_i,
  input  logic        saved_choice_pred_i,
  input  logic [7:0]  saved_history_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        predict_taken_o,
  output logic        bimod_prediction_o,
  output logic        twolevel_prediction_o,
  output logic        choice_prediction_o,
  output logic [7:0]  history_row_o
);

  // Derived geometry
  localparam int unsigned PhtRows  = 1 << HISTORY_BITS;
  localparam int unsigned PhtSize  = PHT_COLUMNS * PhtRows;
  localparam int unsigned BimAw    = (BIMOD_ENTRIES > 1) ? $clog2(BIMOD_ENTRIES) : 1;
  localparam int unsigned ChoAw    = (CHOICE_ENTRIES > 1) ? $clog2(CHOICE_ENTRIES) : 1;
  localparam int unsigned HisAw    = (HISTORY_REGS > 1) ? $clog2(HISTORY_REGS) : 1;
  localparam int unsigned PhtAw    = (PhtSize > 1) ? $clog2(PhtSize) : 1;
  localparam int unsigned ClrA     = (BIMOD_ENTRIES > CHOICE_ENTRIES) ?
                                     BIMOD_ENTRIES : CHOICE_ENTRIES;
  localparam int unsigned ClrB     = (HISTORY_REGS > PhtSize) ? HISTORY_REGS : PhtSize;
  localparam int unsigned ClearLen = (ClrA > ClrB) ? ClrA : ClrB;
  localparam int unsigned ClrW     = (ClearLen > 1) ? $clog2(ClearLen) : 1;

  localparam logic [31:0] BimMask = 32'(BIMOD_ENTRIES - 1);
  localparam logic [31:0] ChoMask = 32'(CHOICE_ENTRIES - 1);
  localparam logic [31:0] HisMask = 32'(HISTORY_REGS - 1);
  localparam logic [31:0] ColMask = 32'(PHT_COLUMNS - 1);

  // --------------------------------------------------------------------------
  // Mode register
  // --------------------------------------------------------------------------
  logic [2:0] mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tbdp_pkg::ModeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Reset sweep
  // --------------------------------------------------------------------------
  logic            clr_active;
  logic [ClrW-1:0] clr_idx;

  tbdp_clear #(
    .CLEAR_LEN (ClearLen)
  ) u_clear (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .active_o (clr_active),
    .idx_o    (clr_idx)
  );

  // --------------------------------------------------------------------------
  // Input acceptance
  // --------------------------------------------------------------------------
  logic [tbdp_pkg::FifoCntW-1:0] fifo_cnt;
  logic [3:0]                    occupancy;
  logic                          in_accept;
  logic                          s1_v_q, s2_v_q;

  assign occupancy  = 4'(fifo_cnt) + 4'(s1_v_q) + 4'(s2_v_q);
  assign in_ready_o = !clr_active && (occupancy < 4'(tbdp_pkg::FifoDepth));
  assign in_accept  = in_valid_i && in_ready_o;

  logic [HisAw-1:0] in_hi;
  assign in_hi = HisAw'(pc_i & HisMask);

  // --------------------------------------------------------------------------
  // Stage 1 registers: history RAM read in flight
  // --------------------------------------------------------------------------
  logic             s1_op_q, s1_uncond_q, s1_internal_q, s1_taken_q;
  logic             s1_sb_q, s1_st_q, s1_sc_q;
  logic [7:0]       s1_shist_q;
  logic [31:0]      s1_pc_q;
  logic [HisAw-1:0] s1_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_accept;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q       <= opcode_i;
      s1_pc_q       <= pc_i;
      s1_uncond_q   <= is_uncond_i;
      s1_internal_q <= is_internal_i;
      s1_taken_q    <= taken_i;
      s1_sb_q       <= saved_bimod_pred_i;
      s1_st_q       <= saved_twolevel_pred_i;
      s1_sc_q       <= saved_choice_pred_i;
      s1_shist_q    <= saved_history_i;
      s1_hi_q       <= in_hi;
    end
  end

  // --------------------------------------------------------------------------
  // History registers: read at accept, read-modify-write in stage 1
  // --------------------------------------------------------------------------
  logic [HISTORY_BITS-1:0] his_rdata, his_cur, his_new, his_wdata;
  logic                    his_we_s1, his_we;
  logic [HisAw-1:0]        his_waddr;
  logic                    his_fwd_v_q;
  logic [HISTORY_BITS-1:0] his_fwd_d_q;

  assign his_cur = his_fwd_v_q ? his_fwd_d_q : his_rdata;
  assign his_new = HISTORY_BITS'({his_cur, s1_taken_q});

  assign his_we_s1 = s1_v_q && (s1_op_q == tbdp_pkg::OP_UPDATE) && !s1_uncond_q &&
                     ((mode_q == tbdp_pkg::MODE_TWO_LEVEL) ||
                      ((mode_q == tbdp_pkg::MODE_COMBINED) && s1_sc_q));

  assign his_we    = clr_active ? (32'(clr_idx) < 32'(HISTORY_REGS)) : his_we_s1;
  assign his_waddr = clr_active ? HisAw'(clr_idx) : s1_hi_q;
  assign his_wdata = clr_active ? '0 : his_new;

  // Same-index write while the next item reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      his_fwd_v_q <= 1'b0;
    end else begin
      his_fwd_v_q <= his_we_s1 && in_accept && (s1_hi_q == in_hi);
    end
  end

  always_ff @(posedge clk_i) begin
    his_fwd_d_q <= his_new;
  end

  tbdp_ram #(
    .WIDTH (HISTORY_BITS),
    .DEPTH (HISTORY_REGS)
  ) u_his_ram (
    .clk_i   (clk_i),
    .we_i    (his_we),
    .waddr_i (his_waddr),
    .wdata_i (his_wdata),
    .re_i    (in_accept),
    .raddr_i (in_hi),
    .rdata_o (his_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: counter table addresses
  // --------------------------------------------------------------------------
  logic [HISTORY_BITS-1:0] s1_row;
  logic [BimAw-1:0]        s1_bi;
  logic [ChoAw-1:0]        s1_ci;
  logic [PhtAw-1:0]        s1_pi;

  // Lookup uses the live history, update the saved one
  assign s1_row = (s1_op_q == tbdp_pkg::OP_LOOKUP) ? his_cur : HISTORY_BITS'(s1_shist_q);
  assign s1_bi  = BimAw'(s1_pc_q & BimMask);
  assign s1_ci  = ChoAw'(s1_pc_q & ChoMask);
  assign s1_pi  = PhtAw'(PhtAw'(s1_row) * PhtAw'(PHT_COLUMNS)) +
                  PhtAw'(s1_pc_q & ColMask);

  // --------------------------------------------------------------------------
  // Stage 2 registers
  // --------------------------------------------------------------------------
  logic                    s2_op_q, s2_uncond_q, s2_internal_q, s2_taken_q;
  logic                    s2_sb_q, s2_st_q, s2_sc_q;
  logic [HISTORY_BITS-1:0] s2_row_q;
  logic [BimAw-1:0]        s2_bi_q;
  logic [ChoAw-1:0]        s2_ci_q;
  logic [PhtAw-1:0]        s2_pi_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_op_q       <= s1_op_q;
      s2_uncond_q   <= s1_uncond_q;
      s2_internal_q <= s1_internal_q;
      s2_taken_q    <= s1_taken_q;
      s2_sb_q       <= s1_sb_q;
      s2_st_q       <= s1_st_q;
      s2_sc_q       <= s1_sc_q;
      s2_row_q      <= s1_row;
      s2_bi_q       <= s1_bi;
      s2_ci_q       <= s1_ci;
      s2_pi_q       <= s1_pi;
    end
  end

  // --------------------------------------------------------------------------
  // Counter tables: read in stage 1, read-modify-write in stage 2
  // --------------------------------------------------------------------------
  logic [1:0] bim_rdata, cho_rdata, pht_rdata;
  logic [1:0] bim_cur, cho_cur, pht_cur;
  logic [1:0] bim_new, cho_new, pht_new;
  logic       bim_we_s2, cho_we_s2, pht_we_s2, upd_ok;
  logic       bim_fwd_v_q, cho_fwd_v_q, pht_fwd_v_q;
  logic [1:0] bim_fwd_d_q, cho_fwd_d_q, pht_fwd_d_q;

  assign bim_cur = bim_fwd_v_q ? bim_fwd_d_q : bim_rdata;
  assign cho_cur = cho_fwd_v_q ? cho_fwd_d_q : cho_rdata;
  assign pht_cur = pht_fwd_v_q ? pht_fwd_d_q : pht_rdata;

  assign upd_ok = s2_v_q && (s2_op_q == tbdp_pkg::OP_UPDATE) && !s2_uncond_q;

  assign bim_we_s2 = upd_ok && ((mode_q == tbdp_pkg::MODE_BIMODAL) ||
                                ((mode_q == tbdp_pkg::MODE_COMBINED) && !s2_sc_q));
  assign pht_we_s2 = upd_ok && ((mode_q == tbdp_pkg::MODE_TWO_LEVEL) ||
                                ((mode_q == tbdp_pkg::MODE_COMBINED) && s2_sc_q));
  // Choice trains only when the sub-predictions disagreed
  assign cho_we_s2 = upd_ok && (mode_q == tbdp_pkg::MODE_COMBINED) && (s2_sb_q != s2_st_q);

  assign bim_new = tbdp_pkg::train(bim_cur, s2_taken_q);
  assign pht_new = tbdp_pkg::train(pht_cur, s2_taken_q);
  assign cho_new = tbdp_pkg::train(cho_cur, s2_sb_q != s2_taken_q);

  // Forwarding to the item one stage behind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bim_fwd_v_q <= 1'b0;
      cho_fwd_v_q <= 1'b0;
      pht_fwd_v_q <= 1'b0;
    end else begin
      bim_fwd_v_q <= bim_we_s2 && s1_v_q && (s2_bi_q == s1_bi);
      cho_fwd_v_q <= cho_we_s2 && s1_v_q && (s2_ci_q == s1_ci);
      pht_fwd_v_q <= pht_we_s2 && s1_v_q && (s2_pi_q == s1_pi);
    end
  end

  always_ff @(posedge clk_i) begin
    bim_fwd_d_q <= bim_new;
    cho_fwd_d_q <= cho_new;
    pht_fwd_d_q <= pht_new;
  end

  logic             bim_we, cho_we, pht_we;
  logic [BimAw-1:0] bim_waddr;
  logic [ChoAw-1:0] cho_waddr;
  logic [PhtAw-1:0] pht_waddr;
  logic [1:0]       bim_wdata, cho_wdata, pht_wdata;

  assign bim_we    = clr_active ? (32'(clr_idx) < 32'(BIMOD_ENTRIES)) : bim_we_s2;
  assign bim_waddr = clr_active ? BimAw'(clr_idx) : s2_bi_q;
  assign bim_wdata = clr_active ? tbdp_pkg::CtrWeakTaken : bim_new;

  assign cho_we    = clr_active ? (32'(clr_idx) < 32'(CHOICE_ENTRIES)) : cho_we_s2;
  assign cho_waddr = clr_active ? ChoAw'(clr_idx) : s2_ci_q;
  assign cho_wdata = clr_active ? tbdp_pkg::CtrWeakTaken : cho_new;

  assign pht_we    = clr_active ? (32'(clr_idx) < 32'(PhtSize)) : pht_we_s2;
  assign pht_waddr = clr_active ? PhtAw'(clr_idx) : s2_pi_q;
  assign pht_wdata = clr_active ? tbdp_pkg::CtrWeakTaken : pht_new;

  tbdp_ram #(
    .WIDTH (2),
    .DEPTH (BIMOD_ENTRIES)
  ) u_bim_ram (
    .clk_i   (clk_i),
    .we_i    (bim_we),
    .waddr_i (bim_waddr),
    .wdata_i (bim_wdata),
    .re_i    (s1_v_q),
    .raddr_i (s1_bi),
    .rdata_o (bim_rdata)
  );

  tbdp_ram #(
    .WIDTH (2),
    .DEPTH (CHOICE_ENTRIES)
  ) u_cho_ram (
    .clk_i   (clk_i),
    .we_i    (cho_we),
    .waddr_i (cho_waddr),
    .wdata_i (cho_wdata),
    .re_i    (s1_v_q),
    .raddr_i (s1_ci),
    .rdata_o (cho_rdata)
  );

  tbdp_ram #(
    .WIDTH (2),
    .DEPTH (PhtSize)
  ) u_pht_ram (
    .clk_i   (clk_i),
    .we_i    (pht_we),
    .waddr_i (pht_waddr),
    .wdata_i (pht_wdata),
    .re_i    (s1_v_q),
    .raddr_i (s1_pi),
    .rdata_o (pht_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 2: result
  // --------------------------------------------------------------------------
  tbdp_pkg::result_t res;
  logic              bp, tp, cp;

  // Counter above one is its top bit
  assign bp = bim_cur[1];
  assign tp = pht_cur[1];
  assign cp = cho_cur[1];

  always_comb begin
    res = '0;
    if (s2_op_q == tbdp_pkg::OP_LOOKUP) begin
      if (s2_uncond_q || s2_internal_q) begin
        res.predict_taken = 1'b1;
      end else begin
        case (mode_q)
          tbdp_pkg::MODE_PERFECT: begin
            res.predict_taken = s2_taken_q;
          end
          tbdp_pkg::MODE_TAKEN: begin
            res.predict_taken = 1'b1;
          end
          tbdp_pkg::MODE_BIMODAL: begin
            res.predict_taken    = bp;
            res.bimod_prediction = bp;
          end
          tbdp_pkg::MODE_TWO_LEVEL: begin
            res.predict_taken       = tp;
            res.twolevel_prediction = tp;
            res.history_row         = 8'(s2_row_q);
          end
          tbdp_pkg::MODE_COMBINED: begin
            res.predict_taken       = cp ? tp : bp;
            res.bimod_prediction    = bp;
            res.twolevel_prediction = tp;
            res.choice_prediction   = cp;
            res.history_row         = 8'(s2_row_q);
          end
          default: begin
            res = '0;
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  tbdp_pkg::result_t out_res;

  tbdp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_v_q),
    .push_data_i (res),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_res),
    .count_o     (fifo_cnt)
  );

  assign predict_taken_o       = out_res.predict_taken;
  assign bimod_prediction_o    = out_res.bimod_prediction;
  assign twolevel_prediction_o = out_res.twolevel_prediction;
  assign choice_prediction_o   = out_res.choice_prediction;
  assign history_row_o         = out_res.history_row;

endmodule
